FILE: rtl/ptt_pkg.sv
package ptt_pkg;

  localparam int unsigned Entries  = 64;
  localparam int unsigned IdxW     = $clog2(Entries);
  localparam int unsigned PageW    = 58;

  typedef enum logic [1:0] {
    ACT_MAP       = 2'd0,
    ACT_UNMAP     = 2'd1,
    ACT_TRANSLATE = 2'd2,
    ACT_NONE      = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_ENTRY = 3'd1,
    ST_SPANS    = 3'd2,
    ST_FULL     = 3'd3,
    ST_MISALIGN = 3'd4
  } status_e;

  localparam logic CfgPageShift = 1'b0;
  localparam logic CfgRecvMode  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic apply;
    logic finish;
    logic out_load;
  } ptt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic run_done;
    logic early_done;
  } ptt_sts_t;

  localparam logic [31:0] NoCid = 32'hFFFF_FFFF;

endpackage

FILE: rtl/ptt_ctrl.sv
module ptt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ptt_pkg::ptt_sts_t sts_i,
  output ptt_pkg::ptt_cmd_t cmd_o
);

  ptt_pkg::state_e state_q, state_d;
  logic            ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ptt_pkg::S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  logic out_free;
  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ptt_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ptt_pkg::S_SCAN;
      end
      ptt_pkg::S_SCAN: begin
        if (sts_i.early_done) state_d = ptt_pkg::S_OUT;
        else if (sts_i.scan_last) state_d = ptt_pkg::S_APPLY;
      end
      ptt_pkg::S_APPLY: begin
        if (sts_i.run_done) state_d = ptt_pkg::S_OUT;
        else state_d = ptt_pkg::S_SCAN;
      end
      ptt_pkg::S_OUT: begin
        if (out_free) state_d = ptt_pkg::S_IDLE;
      end
      default: state_d = ptt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    ovalid_d   = ovalid_q && !out_ready_i;
    case (state_q)
      ptt_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.load   = in_valid_i;
      end
      ptt_pkg::S_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ptt_pkg::S_APPLY: begin
        cmd_o.apply      = 1'b1;
        cmd_o.scan_start = !sts_i.run_done;
      end
      ptt_pkg::S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = ovalid_q;

endmodule

FILE: rtl/ptt_dp.sv
module ptt_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptt_pkg::ptt_cmd_t cmd_i,
  output ptt_pkg::ptt_sts_t sts_o,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic [1:0]        action_i,
  input  logic [63:0]       addr_i,
  input  logic [63:0]       target_addr_i,
  input  logic [6:0]        page_count_i,
  input  logic [15:0]       stride_pages_i,
  input  logic [31:0]       dest_cid_i,
  input  logic [31:0]       dest_sub_cid_i,
  input  logic [15:0]       access_size_i,
  output logic [2:0]        status_o,
  output logic [63:0]       trans_addr_o,
  output logic [31:0]       out_cid_o,
  output logic [31:0]       out_sub_cid_o,
  output logic              cid_valid_o
);

  localparam int unsigned IW = ptt_pkg::IdxW;
  localparam int unsigned PW = ptt_pkg::PageW;

  logic [4:0] shift_q;
  logic       recv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 5'd12;
      recv_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_i) begin
      if (cfg_index_i == ptt_pkg::CfgPageShift) shift_q <= cfg_data_i[4:0];
      else recv_q <= cfg_data_i[0];
    end
  end

  logic [4:0] sh;
  always_comb begin
    if (shift_q < 5'd6) sh = 5'd6;
    else if (shift_q > 5'd30) sh = 5'd30;
    else sh = shift_q;
  end

  logic [63:0] psize, offmask;
  assign psize   = 64'd1 << sh;
  assign offmask = psize - 64'd1;

  logic [ptt_pkg::Entries-1:0] valid_q;
  logic [PW-1:0]               page_mem [ptt_pkg::Entries];
  logic [63:0]                 tgt_mem  [ptt_pkg::Entries];
  logic [31:0]                 cid_mem  [ptt_pkg::Entries];
  logic [31:0]                 sub_mem  [ptt_pkg::Entries];

  logic [1:0]  act_q;
  logic [63:0] addr_q, tgt_q, step_q;
  logic [6:0]  cnt_q;
  logic [31:0] cid_q, sub_q;
  logic [15:0] size_q;
  logic [2:0]  st_q;
  logic [IW:0] scan_q;
  logic        hit_q, free_ok_q;
  logic [IW-1:0] hit_idx_q, free_idx_q;

  logic [IW-1:0] si;
  assign si = scan_q[IW-1:0];

  logic [PW-1:0] cur_page;
  assign cur_page = PW'(addr_q >> sh);

  logic [PW-1:0] rd_page_q;
  logic [63:0]   rd_tgt_q;
  logic [31:0]   rd_cid_q, rd_sub_q;
  logic          rd_val;
  logic [IW-1:0] rd_idx_q;

  always_ff @(posedge clk_i) begin
    rd_page_q <= page_mem[si];
    rd_tgt_q  <= tgt_mem[hit_idx_q];
    rd_cid_q  <= cid_mem[hit_idx_q];
    rd_sub_q  <= sub_mem[hit_idx_q];
    rd_idx_q  <= si;
  end

  logic rd_live_q;
  assign rd_val = valid_q[rd_idx_q];

  logic misalign;
  assign misalign = (addr_i & offmask) != 64'd0;

  logic mem_done;
  assign mem_done = (act_q == ptt_pkg::ACT_MAP || act_q == ptt_pkg::ACT_UNMAP)
                    && (cnt_q == 7'd0);
  assign sts_o.early_done = !rd_live_q && (mem_done
                    || (act_q == ptt_pkg::ACT_NONE) || (st_q == ptt_pkg::ST_MISALIGN));
  assign sts_o.scan_last  = scan_q == (IW+1)'(ptt_pkg::Entries);

  logic run_done;
  always_comb begin
    run_done = 1'b1;
    if (act_q == ptt_pkg::ACT_MAP) run_done = !(hit_q || free_ok_q) || (cnt_q == 7'd1);
    else if (act_q == ptt_pkg::ACT_UNMAP) run_done = cnt_q == 7'd1;
  end
  assign sts_o.run_done = run_done;

  logic [63:0] trans;
  assign trans = rd_tgt_q + (addr_q & offmask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      scan_q     <= '0;
      rd_live_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_ok_q  <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
    end else begin
      rd_live_q <= cmd_i.scan_step && !sts_o.scan_last;
      if (cmd_i.load || cmd_i.scan_start) begin
        scan_q    <= '0;
        hit_q     <= 1'b0;
        free_ok_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (!sts_o.scan_last) scan_q <= scan_q + (IW+1)'(1);
        if (rd_live_q) begin
          if (rd_val && rd_page_q == cur_page && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= rd_idx_q;
          end
          if (!rd_val && !free_ok_q) begin
            free_ok_q  <= 1'b1;
            free_idx_q <= rd_idx_q;
          end
        end
      end
      if (cmd_i.apply) begin
        if (act_q == ptt_pkg::ACT_MAP) begin
          if (hit_q) valid_q[hit_idx_q] <= 1'b1;
          else if (free_ok_q) valid_q[free_idx_q] <= 1'b1;
        end else if (act_q == ptt_pkg::ACT_UNMAP && hit_q) begin
          valid_q[hit_idx_q] <= 1'b0;
        end
      end
    end
  end

  logic [IW-1:0] widx;
  assign widx = hit_q ? hit_idx_q : free_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && act_q == ptt_pkg::ACT_MAP && (hit_q || free_ok_q)) begin
      page_mem[widx] <= cur_page;
      tgt_mem[widx]  <= tgt_q;
      cid_mem[widx]  <= cid_q;
      sub_mem[widx]  <= sub_q;
    end
  end

  logic [2:0]  res_status;
  logic [63:0] res_trans;
  logic [31:0] res_cid, res_sub;
  logic        res_cv;

  always_comb begin
    res_status = st_q;
    res_trans  = 64'd0;
    res_cid    = ptt_pkg::NoCid;
    res_sub    = ptt_pkg::NoCid;
    res_cv     = 1'b0;
    if (act_q == ptt_pkg::ACT_TRANSLATE) begin
      if (!hit_q) res_status = ptt_pkg::ST_NO_ENTRY;
      else begin
        res_trans  = trans;
        res_status = ((65'(trans & offmask) + 65'(size_q)) > 65'(psize))
                     ? ptt_pkg::ST_SPANS : ptt_pkg::ST_OK;
        if (!recv_q) begin
          res_cid = rd_cid_q;
          res_sub = rd_sub_q;
          res_cv  = 1'b1;
        end
      end
    end
  end

  // step = psize * stride, one shift of the zero-extended 16-bit stride
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= action_i;
      addr_q   <= addr_i;
      tgt_q    <= target_addr_i;
      cnt_q    <= page_count_i;
      cid_q    <= dest_cid_i;
      sub_q    <= dest_sub_cid_i;
      size_q   <= access_size_i;
      step_q   <= 64'(stride_pages_i) << sh;
      st_q     <= ((action_i == ptt_pkg::ACT_MAP || action_i == ptt_pkg::ACT_UNMAP)
                   && misalign) ? ptt_pkg::ST_MISALIGN : ptt_pkg::ST_OK;
    end else if (cmd_i.apply) begin
      if (act_q == ptt_pkg::ACT_MAP) begin
        if (!(hit_q || free_ok_q)) st_q <= ptt_pkg::ST_FULL;
        else begin
          addr_q <= addr_q + step_q;
          tgt_q  <= tgt_q + step_q;
          cnt_q  <= cnt_q - 7'd1;
        end
      end else if (act_q == ptt_pkg::ACT_UNMAP) begin
        if (!hit_q) st_q <= ptt_pkg::ST_NO_ENTRY;
        addr_q <= addr_q + psize;
        cnt_q  <= cnt_q - 7'd1;
      end
    end
    if (cmd_i.out_load) begin
      status_o      <= res_status;
      trans_addr_o  <= res_trans;
      out_cid_o     <= res_cid;
      out_sub_cid_o <= res_sub;
      cid_valid_o   <= res_cv;
    end
  end

endmodule

FILE: rtl/page_translation_table_top.sv
// Page translation table, 64 entries.
// Input channel in_valid_i/in_ready_o carries one action per transaction:
// map a run of pages, unmap a run, or translate one address.
// Output channel out_valid_o/out_ready_i returns exactly one result per
// input transaction: status, translated address and destination ids.
// Config channel cfg_valid_i/cfg_ready_o writes page_shift (index 0) or
// recv_mode (index 1); write only while the block is idle.
// Flow: each page lookup scans all 64 slots through one registered read
// port. A translate result follows one scan; a map or unmap run repeats
// a scan and an apply step for each page, and a misaligned, empty or
// unknown action returns without a scan.
// One item is in flight at a time; the next input is taken the cycle after
// the result is loaded. Reset clears all valid bits, page_shift to 12,
// recv_mode to 0. A stalled receiver holds the result in the output
// register; the next item is accepted once the result is loaded.
module page_translation_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [63:0] addr_i,
  input  logic [63:0] target_addr_i,
  input  logic [6:0]  page_count_i,
  input  logic [15:0] stride_pages_i,
  input  logic [31:0] dest_cid_i,
  input  logic [31:0] dest_sub_cid_i,
  input  logic [15:0] access_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] trans_addr_o,
  output logic [31:0] out_cid_o,
  output logic [31:0] out_sub_cid_o,
  output logic        cid_valid_o
);

  ptt_pkg::ptt_cmd_t cmd;
  ptt_pkg::ptt_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ptt_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  ptt_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i,
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .action_i,
    .addr_i,
    .target_addr_i,
    .page_count_i,
    .stride_pages_i,
    .dest_cid_i,
    .dest_sub_cid_i,
    .access_size_i,
    .status_o,
    .trans_addr_o,
    .out_cid_o,
    .out_sub_cid_o,
    .cid_valid_o
  );

endmodule

FILE: rtl/ptt_checker.sv
module ptt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic        cid_valid_o,
  input logic [63:0] trans_addr_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ptt_pkg::ST_MISALIGN)
    else $error("bad status");

  a_cid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cid_valid_o |->
      (status_o == ptt_pkg::ST_OK || status_o == ptt_pkg::ST_SPANS))
    else $error("cid valid without hit");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ptt_pkg::ST_NO_ENTRY |->
      trans_addr_o == 64'd0 && !cid_valid_o)
    else $error("miss with data");

endmodule

bind page_translation_table_top ptt_checker u_ptt_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .status_o,
  .cid_valid_o,
  .trans_addr_o
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ptt_pkg::*;

  localparam int unsigned StallLimit = 40000;

  typedef struct {
    action_e     act;
    logic [63:0] addr;
    logic [63:0] target;
    logic [6:0]  count;
    logic [15:0] stride;
    logic [31:0] cid;
    logic [31:0] sub_cid;
    logic [15:0] size;
  } cmd_t;

  typedef struct {
    status_e     status;
    logic [63:0] trans;
    logic [31:0] cid;
    logic [31:0] sub_cid;
    logic        cid_valid;
  } xlat_t;

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  action_i;
  logic [63:0] addr_i, target_addr_i;
  logic [6:0]  page_count_i;
  logic [15:0] stride_pages_i, access_size_i;
  logic [31:0] dest_cid_i, dest_sub_cid_i;
  logic        out_valid_o, out_ready_i;
  logic [2:0]  status_o;
  logic [63:0] trans_addr_o;
  logic [31:0] out_cid_o, out_sub_cid_o;
  logic        cid_valid_o;

  page_translation_table_top dut (.*);

  // mirror of the table
  logic [4:0]  shift_reg;
  logic        recv_reg;
  logic        map_valid [Entries];
  logic [57:0] map_page [Entries];
  logic [63:0] map_target [Entries];
  logic [31:0] map_cid [Entries];
  logic [31:0] map_sub [Entries];

  cmd_t  cmd_q[$];
  xlat_t xlat_q[$];
  cmd_t  next_cmd;
  int    send_idle, recv_idle;
  int    errors;
  int    stall_cnt;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int eff_shift(logic [4:0] s);
    if (s < 6) return 6;
    if (s > 30) return 30;
    return s;
  endfunction

  function automatic int lookup(logic [57:0] pg);
    for (int i = 0; i < Entries; i++)
      if (map_valid[i] && map_page[i] == pg) return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < Entries; i++)
      if (!map_valid[i]) return i;
    return -1;
  endfunction

  task automatic apply_cmd(input cmd_t c, output xlat_t r);
    int          sh;
    int          s;
    logic [63:0] psize, offm, a, t, step;
    logic [57:0] pg;
    sh    = eff_shift(shift_reg);
    psize = 64'd1 << sh;
    offm  = psize - 1;
    a     = c.addr;
    t     = c.target;
    r     = '{ST_OK, 64'd0, NoCid, NoCid, 1'b0};
    if (c.act == ACT_MAP || c.act == ACT_UNMAP) begin
      if ((a & offm) != 0) begin
        r.status = ST_MISALIGN;
      end else if (c.act == ACT_MAP) begin
        step = psize * c.stride;
        for (int i = 0; i < c.count; i++) begin
          pg = 58'(a >> sh);
          s  = lookup(pg);
          if (s < 0) s = free_slot();
          if (s < 0) begin
            r.status = ST_FULL;
            break;
          end
          map_valid[s]  = 1'b1;
          map_page[s]   = pg;
          map_target[s] = t;
          map_cid[s]    = c.cid;
          map_sub[s]    = c.sub_cid;
          a += step;
          t += step;
        end
      end else begin
        for (int i = 0; i < c.count; i++) begin
          s = lookup(58'(a >> sh));
          if (s < 0) r.status = ST_NO_ENTRY;
          else map_valid[s] = 1'b0;
          a += psize;
        end
      end
    end else if (c.act == ACT_TRANSLATE) begin
      s = lookup(58'(a >> sh));
      if (s < 0) begin
        r.status = ST_NO_ENTRY;
      end else begin
        r.trans = map_target[s] + (a & offm);
        if ((r.trans & offm) + c.size > psize) r.status = ST_SPANS;
        if (!recv_reg) begin
          r.cid       = map_cid[s];
          r.sub_cid   = map_sub[s];
          r.cid_valid = 1'b1;
        end
      end
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
      if (!in_valid_i || in_ready_o) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_cmd = cmd_q.pop_front();
          in_valid_i     <= 1'b1;
          action_i       <= next_cmd.act;
          addr_i         <= next_cmd.addr;
          target_addr_i  <= next_cmd.target;
          page_count_i   <= next_cmd.count;
          stride_pages_i <= next_cmd.stride;
          dest_cid_i     <= next_cmd.cid;
          dest_sub_cid_i <= next_cmd.sub_cid;
          access_size_i  <= next_cmd.size;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cmd_t  c;
    xlat_t r, e;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgPageShift) shift_reg = cfg_data_i[4:0];
        else recv_reg = cfg_data_i[0];
      end
      if (in_valid_i && in_ready_o) begin
        c = '{action_e'(action_i), addr_i, target_addr_i, page_count_i, stride_pages_i,
              dest_cid_i, dest_sub_cid_i, access_size_i};
        apply_cmd(c, r);
        xlat_q.push_back(r);
      end
      if (out_valid_o && out_ready_i) begin
        if (xlat_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          errors++;
        end else begin
          e = xlat_q.pop_front();
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o);
            errors++;
          end
          if (trans_addr_o !== e.trans) begin
            $error("trans_addr: expected %h, got %h", e.trans, trans_addr_o);
            errors++;
          end
          if (out_cid_o !== e.cid) begin
            $error("out_cid: expected %h, got %h", e.cid, out_cid_o);
            errors++;
          end
          if (out_sub_cid_o !== e.sub_cid) begin
            $error("out_sub_cid: expected %h, got %h", e.sub_cid, out_sub_cid_o);
            errors++;
          end
          if (cid_valid_o !== e.cid_valid) begin
            $error("cid_valid: expected %0d, got %0d", e.cid_valid, cid_valid_o);
            errors++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cnt = 0;
      end else if (++stall_cnt >= StallLimit) begin
        $display("page_translation_table_top regression: fail");
        $finish;
      end
    end
  end

  task automatic cfg_write(input logic idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (cmd_q.size() == 0 && xlat_q.size() == 0 && !in_valid_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic cmd_t mk(action_e a, logic [63:0] ad, logic [63:0] t,
                              logic [6:0] n, logic [15:0] st, logic [15:0] sz);
    return '{a, ad, t, n, st, $urandom, $urandom, sz};
  endfunction

  function automatic cmd_t rand_cmd(int sh, logic [63:0] base);
    cmd_t        c;
    logic [63:0] ps, pg;
    int          k;
    ps = 64'd1 << sh;
    pg = base + $urandom_range(95);
    k  = $urandom_range(99);
    c  = '{ACT_TRANSLATE, pg << sh, {$urandom, $urandom}, 7'd1, 16'd1,
           $urandom, $urandom, 16'($urandom_range(64))};
    if ($urandom_range(9) == 0) c.size = 16'($urandom);
    if ($urandom_range(24) == 0) c.count = 7'($urandom_range(127));
    else c.count = 7'($urandom_range(1, 4));
    if ($urandom_range(9) < 3)
      c.stride = 16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(3));
    if (k < 35) begin
      c.addr |= {$urandom, $urandom} & (ps - 1);
    end else if (k < 65) begin
      c.act = ACT_MAP;
    end else if (k < 85) begin
      c.act = ACT_UNMAP;
    end else if (k < 92) begin
      c.act  = $urandom_range(1) ? ACT_MAP : ACT_UNMAP;
      c.addr |= 64'($urandom_range(1, int'(ps - 1)));
    end else begin
      c.act    = action_e'(2'($urandom_range(3)));
      c.addr   = {$urandom, $urandom};
      c.count  = 7'($urandom);
      c.stride = 16'($urandom);
    end
    return c;
  endfunction

  initial begin
    logic [4:0]  shifts [6] = '{5'd12, 5'd31, 5'd6, 5'd20, 5'd3, 5'd30};
    logic        modes  [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    int          sh;
    logic [63:0] base, top;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = 1'b0; cfg_data_i = '0;
    in_valid_i = 1'b0; action_i = '0; addr_i = '0; target_addr_i = '0;
    page_count_i = '0; stride_pages_i = '0; dest_cid_i = '0; dest_sub_cid_i = '0;
    access_size_i = '0; out_ready_i = 1'b0;
    shift_reg = 5'd12; recv_reg = 1'b0;
    foreach (map_valid[i]) map_valid[i] = 1'b0;
    errors = 0; stall_cnt = 0;
    send_idle = 7; recv_idle = 52;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin send_idle = 52; recv_idle = 7; end
      if (p == 4) begin send_idle = 0;  recv_idle = 0; end
      cfg_write(CfgPageShift, {27'($urandom), shifts[p]});
      cfg_write(CfgRecvMode, {31'($urandom), modes[p]});
      sh = eff_shift(shifts[p]);
      // drop leftovers from the previous setting
      for (int i = 0; i < Entries; i++)
        if (map_valid[i])
          cmd_q.push_back(mk(ACT_UNMAP, 64'(map_page[i]) << sh, '0, 7'd1, 16'd1, '0));
      if (p == 0) begin
        top = 64'hFFFF_FFFF_FFFF_F000;
        cmd_q.push_back('{ACT_MAP, 64'h0, top, 7'd1, 16'd1, '1, '1, 16'd0});
        cmd_q.push_back(mk(ACT_TRANSLATE, 64'hFFF, '0, 7'd1, 16'd1, 16'd1));
        cmd_q.push_back(mk(ACT_TRANSLATE, 64'hFFF, '0, 7'd1, 16'd1, 16'd2));
        cmd_q.push_back(mk(ACT_TRANSLATE, 64'h0, '0, 7'd1, 16'd1, 16'hFFFF));
        cmd_q.push_back(mk(ACT_TRANSLATE, 64'h0, '0, 7'd1, 16'd1, 16'h1000));
        cmd_q.push_back(mk(ACT_TRANSLATE, 64'h1000, '0, 7'd1, 16'd1, 16'd0));
        cmd_q.push_back(mk(ACT_MAP, 64'h1001, '0, 7'd1, 16'd1, 16'd0));
        cmd_q.push_back(mk(ACT_UNMAP, 64'h0800, '0, 7'd1, 16'd1, 16'd0));
        cmd_q.push_back(mk(ACT_MAP, 64'h5000, '0, 7'd0, 16'd1, 16'd0));
        cmd_q.push_back(mk(ACT_UNMAP, 64'h0, '0, 7'd0, 16'd1, 16'd0));
        cmd_q.push_back(mk(ACT_MAP, 64'h8000, 64'h1234, 7'd3, 16'd0, 16'd0));
        cmd_q.push_back(mk(ACT_TRANSLATE, 64'h8ABC, '0, 7'd1, 16'd1, 16'd4));
        cmd_q.push_back(mk(ACT_MAP, top, top, 7'd2, 16'd1, 16'd0));
        cmd_q.push_back(mk(ACT_TRANSLATE, 64'h0, '0, 7'd1, 16'd1, 16'd8));
        cmd_q.push_back(mk(ACT_TRANSLATE, top | 64'hFFF, '0, 7'd1, 16'd1, 16'd1));
        cmd_q.push_back(mk(ACT_UNMAP, top, '0, 7'd3, 16'd1, 16'd0));
        cmd_q.push_back('{ACT_NONE, '1, '1, '1, '1, '1, '1, '1});
        cmd_q.push_back(mk(ACT_MAP, 64'h10_0000, 64'hFFFF_0000_0000_0000, 7'd127,
                           16'hFFFF, 16'd0));
        cmd_q.push_back(mk(ACT_TRANSLATE, 64'h10_0FFF, '0, 7'd1, 16'd1, 16'd1));
        cmd_q.push_back(mk(ACT_MAP, 64'h7000_0000, '0, 7'd1, 16'd1, 16'd0));
        cmd_q.push_back(mk(ACT_UNMAP, 64'h10_0000, '0, 7'd127, 16'd1, 16'd0));
        wait_idle();
        for (int i = 0; i < Entries; i++)
          if (map_valid[i])
            cmd_q.push_back(mk(ACT_UNMAP, 64'(map_page[i]) << sh, '0, 7'd1, 16'd1, '0));
      end
      base = {$urandom, $urandom} >> sh;
      if (p == 5) base = (64'hFFFF_FFFF_FFFF_FFFF >> sh) - 40;
      for (int n = 0; n < 130; n++) cmd_q.push_back(rand_cmd(sh, base));
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("page_translation_table_top regression: pass");
    else $display("page_translation_table_top regression: fail");
    $finish;
  end

endmodule
